### hw/rtl/flog_pkg.sv
// flog_pkg: shared types, codes and sizing for the fault log
package flog_pkg;

   localparam int LOG_DEPTH = 32;
   localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
   localparam int RIDX_W    = 5;
   localparam int RCMP_W    = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

   typedef enum logic [1:0] {
      REQ_REPORT    = 2'd0,
      REQ_CLEAR     = 2'd1,
      REQ_CLEAR_ALL = 2'd2,
      REQ_READ      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_UPDATED     = 3'd0,
      STS_NEW         = 3'd1,
      STS_DROPPED     = 3'd2,
      STS_CLEARED     = 3'd3,
      STS_NOT_FOUND   = 3'd4,
      STS_ALL_CLEARED = 3'd5,
      STS_READ_OK     = 3'd6,
      STS_READ_OOR    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_RETRY      = 3'd1,
      ACT_RESET_PERI = 3'd2,
      ACT_FAILOVER   = 3'd3,
      ACT_DEGRADE    = 3'd4,
      ACT_SAFE_STOP  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      RS_EMPTY     = 2'd0,
      RS_ACTIVE    = 2'd1,
      RS_RECOVERED = 2'd2
   } rec_state_type;

   typedef enum logic [2:0] {
      SRC_SYSTEM = 3'd0,
      SRC_CAN    = 3'd1,
      SRC_MOTOR  = 3'd2,
      SRC_SENSOR = 3'd3,
      SRC_POWER  = 3'd4
   } source_type;

   localparam logic [1:0] SEV_ERROR    = 2'd2;
   localparam logic [1:0] SEV_CRITICAL = 2'd3;

   typedef enum logic [1:0] {
      WR_NEW   = 2'd0,
      WR_HIT   = 2'd1,
      WR_CLEAR = 2'd2
   } wr_op_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [2:0]        fault_source;
      logic [1:0]        severity;
      logic [31:0]       fault_code;
      logic [31:0]       now_ms;
      logic [RIDX_W-1:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  action;
      logic        safe_state;
      logic [5:0]  record_count;
      logic [2:0]  max_active_level;
      logic [4:0]  rec_index;
      logic [31:0] rec_code;
      logic [2:0]  rec_source;
      logic [1:0]  rec_severity;
      logic [31:0] rec_time;
      logic [15:0] rec_occurrences;
      logic [1:0]  rec_state;
   } rsp_payload_type;

   // broadcast to every cell while a search beat walks the chain
   typedef struct packed {
      logic [31:0]       code;
      logic [RIDX_W-1:0] ridx;
      logic              read_mode;
      logic [CNT_W-1:0]  fill;
   } query_type;

   // search beat handed from cell to cell
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [31:0]      code;
      logic [2:0]       source;
      logic [1:0]       severity;
      logic [31:0]      time_ms;
      logic [15:0]      hits;
      rec_state_type    state;
      logic [2:0]       lvl_all;
      logic [2:0]       lvl_excl;
   } tok_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      wr_op_type        op;
      logic [31:0]      code;
      logic [2:0]       source;
      logic [1:0]       severity;
      logic [31:0]      time_ms;
      logic [15:0]      hits;
   } wr_type;

   function automatic action_type recovery_for(input logic [2:0] src);
      action_type act;
      case (src)
         SRC_CAN:    act = ACT_RESET_PERI;
         SRC_MOTOR:  act = ACT_DEGRADE;
         SRC_SENSOR: act = ACT_FAILOVER;
         SRC_POWER:  act = ACT_SAFE_STOP;
         default:    act = ACT_RETRY;
      endcase
      return act;
   endfunction

endpackage

### hw/rtl/flog_cell.sv
// flog_cell: one log slot plus one stage of the search chain
module flog_cell import flog_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] slot_idx,
   input  query_type        query,
   input  wr_type           wr,
   input  tok_type          tok_i,
   output tok_type          tok_o
);

   logic [31:0]   code_ff, code_in;
   logic [2:0]    source_ff, source_in;
   logic [1:0]    severity_ff, severity_in;
   logic [31:0]   time_ff, time_in;
   logic [15:0]   hits_ff, hits_in;
   rec_state_type status_ff, status_in;
   tok_type       tok_ff, tok_in;

   logic          slot_used;
   logic          active;
   logic          search_hit;
   logic          read_hit;
   logic [2:0]    lvl;

   always_comb begin
      code_in     = code_ff;
      source_in   = source_ff;
      severity_in = severity_ff;
      time_in     = time_ff;
      hits_in     = hits_ff;
      status_in   = status_ff;
      if (wr.en && (wr.idx == slot_idx)) begin
         unique case (wr.op)
            WR_NEW: begin
               code_in     = wr.code;
               source_in   = wr.source;
               severity_in = wr.severity;
               time_in     = wr.time_ms;
               hits_in     = wr.hits;
               status_in   = RS_ACTIVE;
            end
            WR_HIT: begin
               time_in = wr.time_ms;
               hits_in = wr.hits;
            end
            WR_CLEAR: begin
               status_in = RS_RECOVERED;
            end
            default: begin
            end
         endcase
      end
   end

   // slots at or above the fill count hold nothing
   assign slot_used  = CNT_W'(slot_idx) < query.fill;
   assign active     = slot_used && (status_ff == RS_ACTIVE);
   assign search_hit = !query.read_mode && active && !tok_i.found && (code_ff == query.code);
   assign read_hit   = query.read_mode && slot_used
                       && (RCMP_W'(slot_idx) == RCMP_W'(query.ridx));
   assign lvl        = {1'b0, severity_ff} + 3'd1;

   always_comb begin
      tok_in = tok_i;
      if (search_hit || read_hit) begin
         tok_in.found    = 1'b1;
         tok_in.idx      = slot_idx;
         tok_in.code     = code_ff;
         tok_in.source   = source_ff;
         tok_in.severity = severity_ff;
         tok_in.time_ms  = time_ff;
         tok_in.hits     = hits_ff;
         tok_in.state    = status_ff;
      end
      if (active && (lvl > tok_i.lvl_all)) begin
         tok_in.lvl_all = lvl;
      end
      // the level without the record a clear would retire
      if (active && !search_hit && (lvl > tok_i.lvl_excl)) begin
         tok_in.lvl_excl = lvl;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      source_ff   <= source_in;
      severity_ff <= severity_in;
      time_ff     <= time_in;
      hits_ff     <= hits_in;
      status_ff   <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.found    <= tok_in.found;
      tok_ff.idx      <= tok_in.idx;
      tok_ff.code     <= tok_in.code;
      tok_ff.source   <= tok_in.source;
      tok_ff.severity <= tok_in.severity;
      tok_ff.time_ms  <= tok_in.time_ms;
      tok_ff.hits     <= tok_in.hits;
      tok_ff.state    <= tok_in.state;
      tok_ff.lvl_all  <= tok_in.lvl_all;
      tok_ff.lvl_excl <= tok_in.lvl_excl;
   end

   assign tok_o = tok_ff;

endmodule

### hw/rtl/flog_chain.sv
// flog_chain: the row of log cells the search beat walks through
module flog_chain import flog_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  query_type query,
   input  wr_type    wr,
   input  tok_type   tok_head,
   output tok_type   tok_tail
);

   tok_type tok [LOG_DEPTH+1];

   assign tok[0] = tok_head;

   for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
      flog_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_idx (IDX_W'(i)),
         .query    (query),
         .wr       (wr),
         .tok_i    (tok[i]),
         .tok_o    (tok[i+1])
      );
   end

   assign tok_tail = tok[LOG_DEPTH];

endmodule

### hw/rtl/fault_log_table_with_recovery_policy.sv
// fault_log_table_with_recovery_policy: fault log top level with request sequencer
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | req_payload_type
//   rsp_    | out       | rsp_valid / rsp_stall | rsp_payload_type
//
// one request at a time: a search beat walks the LOG_DEPTH cells, one cell a cycle,
// then the result is formed in S_DONE once the output register is free, and the
// next request is taken back in S_IDLE.
// the record update is broadcast to the cells in the cycle after the result is formed.
// reset empties the log and the safe-state latch; record contents are left alone.
// a stalled result sits in the output register while the next request is taken.
module fault_log_table_with_recovery_policy import flog_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   fsm_state_type   state_ff, state_in;
   req_payload_type req_ff, req_in;
   tok_type         head_ff, head_in;
   tok_type         done_ff, done_in;
   wr_type          wr_ff, wr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic            safe_ff, safe_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   query_type       query;
   tok_type         tail;
   logic            req_take;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign query.code      = req_ff.fault_code;
   assign query.ridx      = req_ff.read_index;
   assign query.read_mode = (req_ff.req_type == REQ_READ);
   assign query.fill      = fill_ff;

   flog_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .query    (query),
      .wr       (wr_ff),
      .tok_head (head_ff),
      .tok_tail (tail)
   );

   always_comb begin
      logic       out_free;
      logic [2:0] lvl_new;
      logic [2:0] lvl;
      logic       has_rec;
      logic       accepted;
      logic [15:0] hits_sat;

      out_free = !rsp_valid_ff || !rsp_stall;
      lvl_new  = {1'b0, req_ff.severity} + 3'd1;
      hits_sat = (done_ff.hits == 16'hFFFF) ? done_ff.hits : done_ff.hits + 16'd1;
      lvl      = done_ff.lvl_all;
      has_rec  = 1'b0;
      accepted = 1'b0;

      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      head_in.valid = 1'b0;
      done_in      = done_ff;
      wr_in        = wr_ff;
      wr_in.en     = 1'b0;
      fill_in      = fill_ff;
      safe_in      = safe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in        = req_payload;
               head_in       = '0;
               head_in.valid = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tail.valid) begin
               done_in  = tail;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in                 = '0;
               rsp_in.rec_code        = done_ff.code;
               rsp_in.rec_source      = done_ff.source;
               rsp_in.rec_severity    = done_ff.severity;
               rsp_in.rec_time        = done_ff.time_ms;
               rsp_in.rec_occurrences = done_ff.hits;
               rsp_in.rec_state       = done_ff.state;
               rsp_in.rec_index       = 5'(done_ff.idx);

               wr_in.idx      = done_ff.idx;
               wr_in.op       = WR_HIT;
               wr_in.code     = req_ff.fault_code;
               wr_in.source   = req_ff.fault_source;
               wr_in.severity = req_ff.severity;
               wr_in.time_ms  = req_ff.now_ms;
               wr_in.hits     = hits_sat;

               unique case (req_kind_type'(req_ff.req_type))
                  REQ_REPORT: begin
                     if (done_ff.found) begin
                        has_rec                = 1'b1;
                        accepted               = 1'b1;
                        wr_in.en               = 1'b1;
                        rsp_in.status          = STS_UPDATED;
                        rsp_in.rec_time        = req_ff.now_ms;
                        rsp_in.rec_occurrences = hits_sat;
                     end else if (fill_ff < CNT_W'(LOG_DEPTH)) begin
                        has_rec                = 1'b1;
                        accepted               = 1'b1;
                        wr_in.en               = 1'b1;
                        wr_in.op               = WR_NEW;
                        wr_in.idx              = fill_ff[IDX_W-1:0];
                        wr_in.hits             = 16'd1;
                        fill_in                = fill_ff + CNT_W'(1);
                        rsp_in.status          = STS_NEW;
                        rsp_in.rec_index       = 5'(fill_ff[IDX_W-1:0]);
                        rsp_in.rec_code        = req_ff.fault_code;
                        rsp_in.rec_source      = req_ff.fault_source;
                        rsp_in.rec_severity    = req_ff.severity;
                        rsp_in.rec_time        = req_ff.now_ms;
                        rsp_in.rec_occurrences = 16'd1;
                        rsp_in.rec_state       = RS_ACTIVE;
                        if (lvl_new > lvl) begin
                           lvl = lvl_new;
                        end
                     end else begin
                        rsp_in.status = STS_DROPPED;
                     end
                  end
                  REQ_CLEAR: begin
                     if (done_ff.found) begin
                        has_rec          = 1'b1;
                        wr_in.en         = 1'b1;
                        wr_in.op         = WR_CLEAR;
                        rsp_in.status    = STS_CLEARED;
                        rsp_in.rec_state = RS_RECOVERED;
                        lvl              = done_ff.lvl_excl;
                     end else begin
                        rsp_in.status = STS_NOT_FOUND;
                     end
                  end
                  REQ_CLEAR_ALL: begin
                     fill_in       = '0;
                     lvl           = 3'd0;
                     rsp_in.status = STS_ALL_CLEARED;
                  end
                  REQ_READ: begin
                     has_rec       = done_ff.found;
                     rsp_in.status = done_ff.found ? STS_READ_OK : STS_READ_OOR;
                  end
                  default: begin
                  end
               endcase

               if (accepted) begin
                  if (req_ff.severity == SEV_CRITICAL) begin
                     rsp_in.action = ACT_SAFE_STOP;
                     safe_in       = 1'b1;
                  end else if (req_ff.severity == SEV_ERROR) begin
                     rsp_in.action = recovery_for(req_ff.fault_source);
                  end
               end

               if (!has_rec) begin
                  rsp_in.rec_index       = '0;
                  rsp_in.rec_code        = '0;
                  rsp_in.rec_source      = '0;
                  rsp_in.rec_severity    = '0;
                  rsp_in.rec_time        = '0;
                  rsp_in.rec_occurrences = '0;
                  rsp_in.rec_state       = RS_EMPTY;
               end

               rsp_in.safe_state       = safe_in;
               rsp_in.record_count     = 6'(fill_in);
               rsp_in.max_active_level = lvl;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         safe_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         safe_ff       <= safe_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
         wr_ff.en      <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
         wr_ff.en      <= wr_in.en;
      end
      req_ff            <= req_in;
      head_ff.found     <= head_in.found;
      head_ff.idx       <= head_in.idx;
      head_ff.code      <= head_in.code;
      head_ff.source    <= head_in.source;
      head_ff.severity  <= head_in.severity;
      head_ff.time_ms   <= head_in.time_ms;
      head_ff.hits      <= head_in.hits;
      head_ff.state     <= head_in.state;
      head_ff.lvl_all   <= head_in.lvl_all;
      head_ff.lvl_excl  <= head_in.lvl_excl;
      done_ff           <= done_in;
      wr_ff.idx         <= wr_in.idx;
      wr_ff.op          <= wr_in.op;
      wr_ff.code        <= wr_in.code;
      wr_ff.source      <= wr_in.source;
      wr_ff.severity    <= wr_in.severity;
      wr_ff.time_ms     <= wr_in.time_ms;
      wr_ff.hits        <= wr_in.hits;
      rsp_ff            <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### test/fault_log_checker.sv
// fault_log_checker: watches both channels, tracks the log contents and compares every result beat
module fault_log_checker import flog_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              pending
);

   logic [31:0]   log_code   [LOG_DEPTH];
   logic [2:0]    log_source [LOG_DEPTH];
   logic [1:0]    log_sev    [LOG_DEPTH];
   logic [31:0]   log_time   [LOG_DEPTH];
   logic [15:0]   log_hits   [LOG_DEPTH];
   rec_state_type log_state  [LOG_DEPTH];
   int            log_fill;
   logic          safe_latched;

   rsp_payload_type expected_replies[$];

   task automatic empty_log();
      for (int i = 0; i < LOG_DEPTH; i++) begin
         log_code[i]   = '0;
         log_source[i] = '0;
         log_sev[i]    = '0;
         log_time[i]   = '0;
         log_hits[i]   = '0;
         log_state[i]  = RS_EMPTY;
      end
      log_fill = 0;
   endtask

   function automatic int find_active(input logic [31:0] code);
      int hit;
      hit = -1;
      for (int i = 0; i < log_fill; i++) begin
         if (hit < 0 && log_state[i] == RS_ACTIVE && log_code[i] == code) hit = i;
      end
      return hit;
   endfunction

   function automatic action_type recovery_action(input logic [2:0] src);
      action_type act;
      case (src)
         SRC_CAN:    act = ACT_RESET_PERI;
         SRC_MOTOR:  act = ACT_DEGRADE;
         SRC_SENSOR: act = ACT_FAILOVER;
         SRC_POWER:  act = ACT_SAFE_STOP;
         default:    act = ACT_RETRY;
      endcase
      return act;
   endfunction

   // applies one request to the tracked log and returns the reply it should give
   task automatic update_log(input req_payload_type r, output rsp_payload_type e);
      int slot;
      logic [2:0] level;
      slot  = -1;
      level = '0;
      e     = '0;
      case (r.req_type)
         REQ_REPORT: begin
            slot = find_active(r.fault_code);
            if (slot >= 0) begin
               if (log_hits[slot] != 16'hFFFF) log_hits[slot] = log_hits[slot] + 16'd1;
               log_time[slot] = r.now_ms;
               e.status = STS_UPDATED;
            end else if (log_fill < LOG_DEPTH) begin
               slot             = log_fill;
               log_code[slot]   = r.fault_code;
               log_source[slot] = r.fault_source;
               log_sev[slot]    = r.severity;
               log_time[slot]   = r.now_ms;
               log_hits[slot]   = 16'd1;
               log_state[slot]  = RS_ACTIVE;
               log_fill++;
               e.status = STS_NEW;
            end else begin
               e.status = STS_DROPPED;
            end
            // action follows the reported severity and source, not the stored ones
            if (slot >= 0) begin
               if (r.severity == SEV_CRITICAL) begin
                  e.action     = ACT_SAFE_STOP;
                  safe_latched = 1'b1;
               end else if (r.severity == SEV_ERROR) begin
                  e.action = recovery_action(r.fault_source);
               end
            end
         end
         REQ_CLEAR: begin
            slot = find_active(r.fault_code);
            if (slot >= 0) begin
               log_state[slot] = RS_RECOVERED;
               e.status = STS_CLEARED;
            end else begin
               e.status = STS_NOT_FOUND;
            end
         end
         REQ_CLEAR_ALL: begin
            empty_log();
            e.status = STS_ALL_CLEARED;
         end
         default: begin
            if (int'(r.read_index) < log_fill) begin
               slot = int'(r.read_index);
               e.status = STS_READ_OK;
            end else begin
               e.status = STS_READ_OOR;
            end
         end
      endcase
      for (int i = 0; i < log_fill; i++) begin
         if (log_state[i] == RS_ACTIVE && {1'b0, log_sev[i]} + 3'd1 > level)
            level = {1'b0, log_sev[i]} + 3'd1;
      end
      e.safe_state       = safe_latched;
      e.record_count     = 6'(log_fill);
      e.max_active_level = level;
      if (slot >= 0) begin
         e.rec_index       = 5'(slot);
         e.rec_code        = log_code[slot];
         e.rec_source      = log_source[slot];
         e.rec_severity    = log_sev[slot];
         e.rec_time        = log_time[slot];
         e.rec_occurrences = log_hits[slot];
         e.rec_state       = log_state[slot];
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen, inout bit bad);
      if (seen !== want) begin
         bad = 1'b1;
         $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
      end
   endtask

   task automatic compare_reply(input rsp_payload_type e, input rsp_payload_type a);
      bit bad;
      bad = 1'b0;
      check_field("status", 32'(e.status), 32'(a.status), bad);
      check_field("action", 32'(e.action), 32'(a.action), bad);
      check_field("safe_state", 32'(e.safe_state), 32'(a.safe_state), bad);
      check_field("record_count", 32'(e.record_count), 32'(a.record_count), bad);
      check_field("max_active_level", 32'(e.max_active_level), 32'(a.max_active_level),
                  bad);
      check_field("rec_index", 32'(e.rec_index), 32'(a.rec_index), bad);
      check_field("rec_code", e.rec_code, a.rec_code, bad);
      check_field("rec_source", 32'(e.rec_source), 32'(a.rec_source), bad);
      check_field("rec_severity", 32'(e.rec_severity), 32'(a.rec_severity), bad);
      check_field("rec_time", e.rec_time, a.rec_time, bad);
      check_field("rec_occurrences", 32'(e.rec_occurrences), 32'(a.rec_occurrences), bad);
      check_field("rec_state", 32'(e.rec_state), 32'(a.rec_state), bad);
      if (bad) begin
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         empty_log();
         safe_latched = 1'b0;
         fail_count   = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, expected none got %0h",
                        $time, rsp_payload);
            end else begin
               compare_reply(expected_replies.pop_front(), rsp_payload);
            end
         end
         if (req_valid && !req_stall) begin
            update_log(req_payload, want);
            expected_replies.push_back(want);
         end
      end
      pending <= expected_replies.size();
   end

endmodule

### test/testbench.sv
// testbench: drives requests into the fault log, stalls the result side and gives the verdict
module testbench;
   import flog_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CODE_POOL    = 40;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int burst_left  = 0;

   logic [31:0] code_pool[CODE_POOL];

   fault_log_table_with_recovery_policy i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   fault_log_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_payload_type make_req(input req_kind_type kind,
                                                input logic [2:0] src, input logic [1:0] sev,
                                                input logic [31:0] code, input logic [31:0] now,
                                                input logic [RIDX_W-1:0] ridx);
      req_payload_type r;
      r.req_type     = kind;
      r.fault_source = src;
      r.severity     = sev;
      r.fault_code   = code;
      r.now_ms       = now;
      r.read_index   = ridx;
      return r;
   endfunction

   // offers one beat, waits for it to be taken, then maybe closes the burst
   task automatic send_req(input req_payload_type r);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // result side: stall density changes in stretches, with one long hold-off
   initial begin
      int cyc;
      int stretch;
      int pct;
      cyc = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stretch = $urandom_range(20, 300);
         case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
         endcase
         repeat (stretch) begin
            cyc++;
            if (cyc == 3000) begin
               rsp_stall <= 1'b1;
               repeat (600) @(posedge clock);
            end
            rsp_stall <= ($urandom_range(0, 99) < pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      req_payload_type r;
      int pick;
      logic [31:0] code;
      code_pool[0] = 32'h0000_0000;
      code_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < CODE_POOL; i++) code_pool[i] = $urandom();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty log, every source on an error, critical latch, hit, clears, reads
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(REQ_CLEAR, 3'd0, 2'd0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_SYSTEM, 2'd0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_POWER, SEV_ERROR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        5'd31));
      send_req(make_req(REQ_REPORT, SRC_CAN, SEV_ERROR, 32'h0000_00A1, 32'd100, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_MOTOR, SEV_ERROR, 32'h0000_00A2, 32'd200, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_SENSOR, SEV_ERROR, 32'h0000_00A3, 32'd300, 5'd0));
      send_req(make_req(REQ_REPORT, 3'd5, SEV_ERROR, 32'h0000_00A4, 32'd400, 5'd0));
      send_req(make_req(REQ_REPORT, 3'd7, SEV_ERROR, 32'h0000_00A5, 32'd500, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_SYSTEM, SEV_ERROR, 32'h0000_00A6, 32'd600, 5'd0));
      send_req(make_req(REQ_REPORT, 3'd6, SEV_CRITICAL, 32'h8000_0000, 32'd700, 5'd0));
      // hit with a different source and severity: stored fields stay
      send_req(make_req(REQ_REPORT, SRC_POWER, 2'd1, 32'h0000_00A1, 32'd800, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_CAN, SEV_CRITICAL, 32'h0, 32'd900, 5'd0));
      send_req(make_req(REQ_CLEAR, 3'd0, 2'd0, 32'h0000_00A1, 32'h0, 5'd0));
      send_req(make_req(REQ_CLEAR, 3'd0, 2'd0, 32'h0000_00A1, 32'h0, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_MOTOR, 2'd1, 32'h0000_00A1, 32'd1000, 5'd0));
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd2));
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd9));
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd10));
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd31));
      send_req(make_req(REQ_CLEAR_ALL, 3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
      send_req(make_req(REQ_READ, 3'd0, 2'd0, 32'h0, 32'h0, 5'd0));
      send_req(make_req(REQ_REPORT, SRC_SENSOR, 2'd1, 32'h1234_5678, 32'd1100, 5'd0));

      // random: codes mostly from a small pool so hits, clears and a full log all occur
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 999);
         code = ($urandom_range(0, 9) == 0) ? $urandom() :
                code_pool[$urandom_range(0, CODE_POOL - 1)];
         r = make_req(REQ_READ, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                      code, $urandom(), 5'($urandom_range(0, 31)));
         if (pick < 15)       r.req_type = REQ_CLEAR_ALL;
         else if (pick < 560) r.req_type = REQ_REPORT;
         else if (pick < 760) r.req_type = REQ_CLEAR;
         send_req(r);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/flog_pkg.sv
hw/rtl/flog_cell.sv
hw/rtl/flog_chain.sv
hw/rtl/fault_log_table_with_recovery_policy.sv
test/fault_log_checker.sv
test/testbench.sv
